[rtl/core/alr_pkg.sv]
// Shared constants, types and codes of the antialiased line rasterizer.
package alr_pkg;

   localparam int COORD_FRAC_BITS = 8;
   localparam int COORD_INT_BITS  = 12;
   localparam int GRAD_FRAC_BITS  = 16;
   localparam int COORD_BITS      = COORD_INT_BITS + COORD_FRAC_BITS;
   localparam int DX_BITS         = COORD_BITS + 1;
   localparam int NUM_BITS        = DX_BITS + GRAD_FRAC_BITS;
   localparam int QUOT_BITS       = GRAD_FRAC_BITS + 1;
   localparam int GRAD_BITS       = GRAD_FRAC_BITS + 2;
   localparam int DELTA_BITS      = COORD_FRAC_BITS + 1;
   localparam int PROD_BITS       = GRAD_BITS + DELTA_BITS;
   localparam int EXACT_BITS      = NUM_BITS;
   localparam int MINOR_BITS      = COORD_INT_BITS + GRAD_FRAC_BITS + 2;
   localparam int COL_BITS        = COORD_INT_BITS + 2;
   localparam int GAP_BITS        = COORD_FRAC_BITS + 1;
   localparam int COV_BITS        = GRAD_FRAC_BITS + COORD_FRAC_BITS;
   localparam int FRAC_BITS       = GRAD_FRAC_BITS + 1;
   localparam int DIV_CNT_BITS    = $clog2(NUM_BITS);
   localparam int FRAME_BITS      = 13;
   localparam int OUT_BITS        = 12;
   localparam int OUT_LIMIT       = 4096;
   localparam int COLOR_BITS      = 32;
   localparam int ALPHA_BITS      = 8;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_BITS  = 1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;

   typedef logic signed [COL_BITS-1:0]   col_type;
   typedef logic signed [MINOR_BITS-1:0] minor_type;
   typedef logic signed [GRAD_BITS-1:0]  grad_type;
   typedef logic [GAP_BITS-1:0]          gap_type;

   typedef struct packed {
      logic                  is_load;
      logic                  steep;
      col_type               first_col;
      minor_type             first_minor;
      gap_type               first_gap;
      grad_type              gradient;
      col_type               final_col;
      minor_type             final_minor;
      gap_type               final_gap;
      logic [COLOR_BITS-1:0] color;
   } cmd_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIVIDE,
      FRONT_MULTIPLY,
      FRONT_PUSH
   } front_state_type;

endpackage

[rtl/core/alr_if.sv]
// Valid/ready channel interfaces for the request and pixel response beats.
interface alr_req_if;
   logic                                        valid;
   logic                                        ready;
   logic                                        opcode;
   logic signed [alr_pkg::COORD_BITS-1:0]       start_x;
   logic signed [alr_pkg::COORD_BITS-1:0]       start_y;
   logic signed [alr_pkg::COORD_BITS-1:0]       end_x;
   logic signed [alr_pkg::COORD_BITS-1:0]       end_y;
   logic [alr_pkg::COLOR_BITS-1:0]              line_color;

   modport source (output valid, opcode, start_x, start_y, end_x, end_y, line_color,
                   input ready);
   modport sink   (input valid, opcode, start_x, start_y, end_x, end_y, line_color,
                   output ready);
endinterface

interface alr_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [alr_pkg::OUT_BITS-1:0]     pixel_x;
   logic [alr_pkg::OUT_BITS-1:0]     pixel_y;
   logic [alr_pkg::COLOR_BITS-1:0]   pixel_color;
   logic                             write_enable;
   logic                             last;

   modport source (output valid, pixel_x, pixel_y, pixel_color, write_enable, last,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, write_enable, last,
                   output ready);
endinterface

[rtl/core/alr_front.sv]
// Front end: accepts beats, sets up a line with its gradient division and queues commands.
module alr_front (
   input  logic                clock,
   input  logic                reset,
   alr_req_if.sink             req_bus,
   input  logic                queue_full,
   output logic                push_valid,
   output alr_pkg::cmd_type    push_data
);

   localparam int CF = alr_pkg::COORD_FRAC_BITS;
   localparam int GF = alr_pkg::GRAD_FRAC_BITS;
   localparam int CB = alr_pkg::COORD_BITS;
   localparam int DB = alr_pkg::DX_BITS;
   localparam int NB = alr_pkg::NUM_BITS;

   function automatic alr_pkg::col_type round_coord(input logic signed [CB-1:0] v);
      logic signed [DB-1:0] ve;
      logic [DB-1:0]        mag;
      logic [DB-1:0]        q;
      ve  = DB'(v);
      mag = (ve < 0) ? DB'(-ve) : DB'(ve);
      q   = (mag + DB'(1 << (CF - 1))) >> CF;
      return (ve < 0) ? -$signed(alr_pkg::COL_BITS'(q)) : $signed(alr_pkg::COL_BITS'(q));
   endfunction

   alr_pkg::front_state_type state_ff, state_in;

   logic signed [CB-1:0] ox0_ff, oy0_ff, ox1_ff, oy1_ff;
   logic [DB-1:0]        dx_ff;
   logic                 dy_neg_ff;
   logic                 steep_ff;
   logic [alr_pkg::COLOR_BITS-1:0] color_ff;
   logic [DB-2:0]        rem_ff;
   logic [NB-1:0]        dvd_ff;
   logic [alr_pkg::DIV_CNT_BITS-1:0] cnt_ff;
   alr_pkg::grad_type    grad_ff;
   alr_pkg::col_type     c0_ff, c1_ff;
   logic signed [alr_pkg::PROD_BITS-1:0] prod0_ff, prod1_ff;
   alr_pkg::gap_type     gap0_ff, gap1_ff;

   logic accept;
   logic is_load;

   logic signed [DB-1:0] dxs, dys, a_dx, a_dy;
   logic                 steep;
   logic signed [CB-1:0] sx0, sy0, sx1, sy1;
   logic signed [CB-1:0] nx0, ny0, nx1, ny1;
   logic signed [DB-1:0] ndx, ndy;
   logic [DB-1:0]        ady_mag;
   logic [NB-1:0]        num;

   logic [DB-1:0]        trial;
   logic                 qbit;
   logic [DB-2:0]        rem_in;
   logic [NB-1:0]        dvd_in;
   logic [alr_pkg::QUOT_BITS-1:0] quot;
   alr_pkg::grad_type    grad_in;

   alr_pkg::col_type     c0, c1;
   logic signed [DB:0]   d0w, d1w;
   logic signed [alr_pkg::DELTA_BITS-1:0] delta0, delta1;
   logic signed [DB-1:0] h0, h1;

   logic signed [alr_pkg::EXACT_BITS-1:0] exact0, exact1;

   assign accept  = req_bus.valid && req_bus.ready;
   assign is_load = (req_bus.opcode == alr_pkg::OP_LOAD);

   always_comb begin
      dxs  = DB'(req_bus.end_x) - DB'(req_bus.start_x);
      dys  = DB'(req_bus.end_y) - DB'(req_bus.start_y);
      a_dx = (dxs < 0) ? -dxs : dxs;
      a_dy = (dys < 0) ? -dys : dys;
      steep = a_dy > a_dx;
      sx0 = steep ? req_bus.start_y : req_bus.start_x;
      sy0 = steep ? req_bus.start_x : req_bus.start_y;
      sx1 = steep ? req_bus.end_y : req_bus.end_x;
      sy1 = steep ? req_bus.end_x : req_bus.end_y;
      if (sx0 > sx1) begin
         nx0 = sx1; ny0 = sy1; nx1 = sx0; ny1 = sy0;
      end else begin
         nx0 = sx0; ny0 = sy0; nx1 = sx1; ny1 = sy1;
      end
      ndx = DB'(nx1) - DB'(nx0);
      ndy = DB'(ny1) - DB'(ny0);
      ady_mag = (ndy < 0) ? DB'(-ndy) : DB'(ndy);
      num = NB'({ady_mag, GF'(0)}) + NB'(ndx[DB-1:1]);
   end

   always_comb begin
      trial  = {rem_ff, dvd_ff[NB-1]};
      qbit   = (trial >= dx_ff);
      rem_in = qbit ? (DB-1)'(trial - dx_ff) : trial[DB-2:0];
      dvd_in = {dvd_ff[NB-2:0], qbit};
      quot   = dvd_in[alr_pkg::QUOT_BITS-1:0];
      if (dx_ff == '0) begin
         grad_in = '0;
      end else if (dy_neg_ff) begin
         grad_in = -$signed(alr_pkg::GRAD_BITS'(quot));
      end else begin
         grad_in = $signed(alr_pkg::GRAD_BITS'(quot));
      end
   end

   always_comb begin
      c0  = round_coord(ox0_ff);
      c1  = round_coord(ox1_ff);
      d0w = $signed({(DB+1-CF)'(c0), CF'(0)}) - (DB+1)'(ox0_ff);
      d1w = $signed({(DB+1-CF)'(c1), CF'(0)}) - (DB+1)'(ox1_ff);
      delta0 = d0w[alr_pkg::DELTA_BITS-1:0];
      delta1 = d1w[alr_pkg::DELTA_BITS-1:0];
      h0 = DB'(ox0_ff) + DB'(1 << (CF - 1));
      h1 = DB'(ox1_ff) + DB'(1 << (CF - 1));
   end

   always_comb begin
      exact0 = alr_pkg::EXACT_BITS'($signed({oy0_ff, GF'(0)})) +
               alr_pkg::EXACT_BITS'(prod0_ff);
      exact1 = alr_pkg::EXACT_BITS'($signed({oy1_ff, GF'(0)})) +
               alr_pkg::EXACT_BITS'(prod1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alr_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_bus.ready = 1'b0;
      push_valid    = 1'b0;
      push_data     = '0;
      unique case (state_ff)
         alr_pkg::FRONT_IDLE: begin
            req_bus.ready = !queue_full;
            if (accept) begin
               if (is_load) begin
                  state_in = alr_pkg::FRONT_DIVIDE;
               end else begin
                  push_valid        = 1'b1;
                  push_data.is_load = 1'b0;
               end
            end
         end
         alr_pkg::FRONT_DIVIDE: begin
            if (cnt_ff == alr_pkg::DIV_CNT_BITS'(NB - 1)) begin
               state_in = alr_pkg::FRONT_MULTIPLY;
            end
         end
         alr_pkg::FRONT_MULTIPLY: begin
            state_in = alr_pkg::FRONT_PUSH;
         end
         alr_pkg::FRONT_PUSH: begin
            push_valid            = 1'b1;
            push_data.is_load     = 1'b1;
            push_data.steep       = steep_ff;
            push_data.first_col   = c0_ff;
            push_data.first_minor = alr_pkg::MINOR_BITS'($signed(exact0[alr_pkg::EXACT_BITS-1:CF]));
            push_data.first_gap   = gap0_ff;
            push_data.gradient    = grad_ff;
            push_data.final_col   = c1_ff;
            push_data.final_minor = alr_pkg::MINOR_BITS'($signed(exact1[alr_pkg::EXACT_BITS-1:CF]));
            push_data.final_gap   = gap1_ff;
            push_data.color       = color_ff;
            state_in = alr_pkg::FRONT_IDLE;
         end
         default: begin
            state_in = alr_pkg::FRONT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == alr_pkg::FRONT_IDLE && accept && is_load) begin
         ox0_ff    <= nx0;
         oy0_ff    <= ny0;
         ox1_ff    <= nx1;
         oy1_ff    <= ny1;
         dx_ff     <= DB'(ndx);
         dy_neg_ff <= ndy < 0;
         steep_ff  <= steep;
         color_ff  <= req_bus.line_color;
         rem_ff    <= '0;
         dvd_ff    <= num;
         cnt_ff    <= '0;
      end
      if (state_ff == alr_pkg::FRONT_DIVIDE) begin
         rem_ff  <= rem_in;
         dvd_ff  <= dvd_in;
         cnt_ff  <= cnt_ff + 1'b1;
         grad_ff <= grad_in;
      end
      if (state_ff == alr_pkg::FRONT_MULTIPLY) begin
         c0_ff    <= c0;
         c1_ff    <= c1;
         prod0_ff <= grad_ff * delta0;
         prod1_ff <= grad_ff * delta1;
         gap0_ff  <= alr_pkg::GAP_BITS'(1 << CF) - alr_pkg::GAP_BITS'(h0[CF-1:0]);
         gap1_ff  <= alr_pkg::GAP_BITS'(h1[CF-1:0]);
      end
   end

endmodule

[rtl/core/alr_queue.sv]
// Short command queue between the front end and the pixel back end.
module alr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  alr_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop_ready,
   output logic             pop_valid,
   output alr_pkg::cmd_type pop_data
);

   alr_pkg::cmd_type mem_ff [alr_pkg::QUEUE_DEPTH];
   logic [alr_pkg::QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [alr_pkg::QCNT_BITS-1:0] count_ff;
   logic push, pop;

   assign full      = (count_ff == alr_pkg::QCNT_BITS'(alr_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign push      = push_valid && !full;
   assign pop       = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[rtl/core/alr_back.sv]
// Back end: holds the active line, walks its columns and emits the pixel beats.
module alr_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            pop_valid,
   input  alr_pkg::cmd_type                pop_data,
   output logic                            pop_ready,
   input  logic [alr_pkg::FRAME_BITS-1:0]  frame_width,
   input  logic [alr_pkg::FRAME_BITS-1:0]  frame_height,
   alr_rsp_if.source                       rsp_bus
);

   localparam int GF = alr_pkg::GRAD_FRAC_BITS;
   localparam int CF = alr_pkg::COORD_FRAC_BITS;
   localparam int VB = alr_pkg::COV_BITS + 1;
   localparam int FB = alr_pkg::FRAC_BITS;
   localparam int CB = alr_pkg::COL_BITS;
   localparam int AB = alr_pkg::ALPHA_BITS;
   localparam int WB = AB + VB;

   logic                 active_ff;
   alr_pkg::col_type     cur_ff, final_ff;
   alr_pkg::minor_type   acc_ff, far_y_ff;
   alr_pkg::grad_type    grad_ff;
   alr_pkg::gap_type     far_gap_ff;

   logic                 pair_valid_ff, sel_ff, plast_ff, psteep_ff;
   alr_pkg::col_type     pcol_ff, prow_ff;
   logic [VB-1:0]        cov0_ff, cov1_ff;
   logic [alr_pkg::COLOR_BITS-1:0] pcolor_ff;

   logic                 out_valid_ff, owe_ff, olast_ff;
   logic [alr_pkg::OUT_BITS-1:0] ox_ff, oy_ff;
   logic [alr_pkg::COLOR_BITS-1:0] ocolor_ff;

   logic emit, pop;
   logic interior, produce, last_sel;
   alr_pkg::col_type   sel_col;
   alr_pkg::minor_type sel_minor;
   alr_pkg::gap_type   sel_gap;
   logic [FB-1:0]      frac_v, rem_v;
   logic [VB-1:0]      cov0, cov1;

   alr_pkg::col_type   row, px, py;
   logic [alr_pkg::FRAME_BITS-1:0] lim_w, lim_h;
   logic               inside_frame;
   logic [VB-1:0]      cov;
   logic [AB-1:0]      base_alpha;
   logic [WB-1:0]      scaled;
   logic               we;

   assign emit      = pair_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign pop_ready = !pair_valid_ff || (emit && sel_ff);
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      interior  = 1'b0;
      produce   = 1'b0;
      last_sel  = 1'b0;
      sel_col   = pop_data.first_col;
      sel_minor = pop_data.first_minor;
      sel_gap   = pop_data.first_gap;
      if (pop_data.is_load) begin
         produce = 1'b1;
      end else if (active_ff) begin
         produce = 1'b1;
         if (cur_ff < final_ff) begin
            interior  = 1'b1;
            sel_col   = cur_ff;
            sel_minor = acc_ff;
         end else begin
            last_sel  = 1'b1;
            sel_col   = final_ff;
            sel_minor = far_y_ff;
            sel_gap   = far_gap_ff;
         end
      end
      frac_v = FB'(sel_minor[GF-1:0]);
      rem_v  = FB'(1 << GF) - frac_v;
      if (interior) begin
         cov0 = VB'({rem_v, CF'(0)});
         cov1 = VB'({frac_v, CF'(0)});
      end else begin
         cov0 = VB'((FB + alr_pkg::GAP_BITS)'(rem_v) * (FB + alr_pkg::GAP_BITS)'(sel_gap));
         cov1 = VB'((FB + alr_pkg::GAP_BITS)'(frac_v) * (FB + alr_pkg::GAP_BITS)'(sel_gap));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         pair_valid_ff <= 1'b0;
         sel_ff        <= 1'b0;
      end else if (pop) begin
         pair_valid_ff <= produce;
         sel_ff        <= 1'b0;
         if (pop_data.is_load) begin
            active_ff <= 1'b1;
         end else if (active_ff && !interior) begin
            active_ff <= 1'b0;
         end
      end else if (emit) begin
         sel_ff <= !sel_ff;
         if (sel_ff) begin
            pair_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (pop_data.is_load) begin
            psteep_ff  <= pop_data.steep;
            pcolor_ff  <= pop_data.color;
            grad_ff    <= pop_data.gradient;
            cur_ff     <= pop_data.first_col + 1'b1;
            final_ff   <= pop_data.final_col;
            acc_ff     <= pop_data.first_minor + alr_pkg::MINOR_BITS'(pop_data.gradient);
            far_y_ff   <= pop_data.final_minor;
            far_gap_ff <= pop_data.final_gap;
         end else if (interior) begin
            acc_ff <= acc_ff + alr_pkg::MINOR_BITS'(grad_ff);
            cur_ff <= cur_ff + 1'b1;
         end
         pcol_ff  <= sel_col;
         prow_ff  <= CB'(sel_minor >>> GF);
         cov0_ff  <= cov0;
         cov1_ff  <= cov1;
         plast_ff <= last_sel;
      end
   end

   always_comb begin
      row   = sel_ff ? prow_ff + 1'b1 : prow_ff;
      px    = psteep_ff ? row : pcol_ff;
      py    = psteep_ff ? pcol_ff : row;
      lim_w = (frame_width > alr_pkg::FRAME_BITS'(alr_pkg::OUT_LIMIT)) ?
              alr_pkg::FRAME_BITS'(alr_pkg::OUT_LIMIT) : frame_width;
      lim_h = (frame_height > alr_pkg::FRAME_BITS'(alr_pkg::OUT_LIMIT)) ?
              alr_pkg::FRAME_BITS'(alr_pkg::OUT_LIMIT) : frame_height;
      inside_frame = (px >= 0) && (py >= 0) &&
                     (px < $signed(CB'(lim_w))) && (py < $signed(CB'(lim_h)));
      cov        = sel_ff ? cov1_ff : cov0_ff;
      base_alpha = pcolor_ff[alr_pkg::COLOR_BITS-1 -: AB];
      scaled     = WB'(base_alpha) * WB'(cov) + WB'(1 << (alr_pkg::COV_BITS - 1));
      we         = (cov != '0) && (base_alpha != '0) && inside_frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         owe_ff    <= we;
         olast_ff  <= sel_ff && plast_ff;
         ox_ff     <= we ? px[alr_pkg::OUT_BITS-1:0] : '0;
         oy_ff     <= we ? py[alr_pkg::OUT_BITS-1:0] : '0;
         ocolor_ff <= we ? {scaled[alr_pkg::COV_BITS +: AB],
                            pcolor_ff[alr_pkg::COLOR_BITS-AB-1:0]} : '0;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.pixel_x      = ox_ff;
   assign rsp_bus.pixel_y      = oy_ff;
   assign rsp_bus.pixel_color  = ocolor_ff;
   assign rsp_bus.write_enable = owe_ff;
   assign rsp_bus.last         = olast_ff;

endmodule

[rtl/core/antialiased_line_rasterizer_top.sv]
// Top level of the antialiased line rasterizer with its frame size registers.
// A load beat sets up a line and yields the two pixel beats of the first endpoint column; it
// occupies the front end through the restoring gradient divider, one quotient bit per cycle,
// then a multiply state and a push state. Its first pixel beat passes the queue, the back end's
// pair register and its single output register. Each step beat yields two pixel beats; that
// output register presents one pixel per cycle while the response side is ready. A queue of
// two commands lets the front end accept beats while the back end still waits on the response
// side. Step beats with no active line are accepted and dropped.
module antialiased_line_rasterizer_top (
   input  logic                                clock,
   input  logic                                reset,
   alr_req_if.sink                             req_bus,
   alr_rsp_if.source                           rsp_bus,
   input  logic                                csr_write_enable,
   input  logic [alr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [alr_pkg::FRAME_BITS-1:0]      csr_write_data
);

   logic [alr_pkg::FRAME_BITS-1:0] frame_width_ff, frame_height_ff;
   logic             queue_full, push_valid, pop_valid, pop_ready;
   alr_pkg::cmd_type push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= alr_pkg::FRAME_BITS'(320);
         frame_height_ff <= alr_pkg::FRAME_BITS'(240);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            alr_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_write_data;
            alr_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   alr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   alr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   alr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_data     (pop_data),
      .pop_ready    (pop_ready),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .rsp_bus      (rsp_bus)
   );

endmodule
